// ----- design/spid_pkg.sv -----
// Shared types, register indexes and helpers for the steering PID controller.
package spid_pkg;

  // Widths of the fixed-point quantities.
  localparam int unsigned GainW   = 32;
  localparam int unsigned LimW    = 14;
  localparam int unsigned JumpW   = 7;
  localparam int unsigned PixW    = 9;
  localparam int unsigned AngW    = 15;
  localparam int unsigned AccW    = 48;
  localparam int unsigned CfgIdxW = 3;

  // Reset values of the configuration registers.
  localparam logic [GainW-1:0] PropGainRst  = 32'd322122547;
  localparam logic [GainW-1:0] IntegGainRst = 32'd9395;
  localparam logic [GainW-1:0] DerivGainRst = 32'd698187104;
  localparam logic [LimW-1:0]  AngleLimRst  = 14'd7680;
  localparam logic [JumpW-1:0] JumpLimRst   = 7'd20;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PROP_GAIN   = 3'd0,
    CFG_INTEG_GAIN  = 3'd1,
    CFG_DERIV_GAIN  = 3'd2,
    CFG_ANGLE_LIMIT = 3'd3,
    CFG_JUMP_LIMIT  = 3'd4
  } cfg_idx_e;

  // Current configuration handed from the register file to the datapath.
  typedef struct packed {
    logic [GainW-1:0] prop_gain;
    logic [GainW-1:0] integ_gain;
    logic [GainW-1:0] deriv_gain;
    logic [LimW-1:0]  angle_limit;
    logic [JumpW-1:0] jump_limit;
  } cfg_t;

  // Saturate a 49-bit signed sum to the 48-bit accumulator range.
  function automatic logic signed [AccW-1:0] sat_acc(input logic signed [AccW:0] v);
    logic signed [AccW-1:0] r;
    if (v[AccW] != v[AccW-1]) begin
      r = v[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      r = v[AccW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- design/spid_cfg.sv -----
// Configuration register file of the steering PID controller.
module spid_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [spid_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [spid_pkg::GainW-1:0]          cfg_data_i,
  output spid_pkg::cfg_t                      cfg_o
);

  spid_pkg::cfg_t cfg_q;

  // Writes are always taken; the register file never holds one back.
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Register writes; indexes past the last register are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain   <= spid_pkg::PropGainRst;
      cfg_q.integ_gain  <= spid_pkg::IntegGainRst;
      cfg_q.deriv_gain  <= spid_pkg::DerivGainRst;
      cfg_q.angle_limit <= spid_pkg::AngleLimRst;
      cfg_q.jump_limit  <= spid_pkg::JumpLimRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (spid_pkg::cfg_idx_e'(cfg_index_i))
        spid_pkg::CFG_PROP_GAIN:   cfg_q.prop_gain   <= cfg_data_i;
        spid_pkg::CFG_INTEG_GAIN:  cfg_q.integ_gain  <= cfg_data_i;
        spid_pkg::CFG_DERIV_GAIN:  cfg_q.deriv_gain  <= cfg_data_i;
        spid_pkg::CFG_ANGLE_LIMIT: cfg_q.angle_limit <= cfg_data_i[spid_pkg::LimW-1:0];
        spid_pkg::CFG_JUMP_LIMIT:  cfg_q.jump_limit  <= cfg_data_i[spid_pkg::JumpW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- design/spid_core.sv -----
// PID datapath with its controller state: glitch check, gains, accumulators and clamp.
module spid_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  spid_pkg::cfg_t                      cfg_i,
  input  logic                                commit_i,
  input  logic signed [spid_pkg::PixW-1:0]    meas_i,
  input  logic signed [spid_pkg::PixW-1:0]    prev_i,
  output logic signed [spid_pkg::AngW-1:0]    angle_o,
  output logic                                glitch_o
);

  localparam int unsigned AccW = spid_pkg::AccW;
  localparam int unsigned PixW = spid_pkg::PixW;
  localparam int unsigned AngW = spid_pkg::AngW;
  localparam int unsigned TotW = AccW + 2;
  localparam int unsigned RndW = TotW - 20;

  logic signed [AccW-1:0] integ_q, integ_d;
  logic signed [AccW-1:0] deriv_q, deriv_d;
  logic signed [PixW-1:0] last_err_q;
  logic signed [PixW-1:0] last_meas_q;
  logic signed [AngW-1:0] held_q;

  logic signed [PixW:0]   jump;
  logic        [PixW:0]   jump_mag;
  logic                   glitch;
  logic signed [PixW-1:0] err;
  logic signed [PixW:0]   err_sum;
  logic signed [PixW:0]   meas_diff;
  logic signed [41:0]     prop_prod;
  logic signed [42:0]     integ_prod;
  logic signed [42:0]     deriv_prod;
  logic signed [AccW:0]   integ_sum;
  logic signed [AccW:0]   deriv_sum;
  logic signed [TotW-1:0] total;
  logic signed [TotW-1:0] rounded;
  logic signed [RndW-1:0] ang_q88;
  logic signed [RndW-1:0] lim;
  logic signed [AngW-1:0] ang_new;

  // Plausibility check: the jump between the two offsets against twice the bound.
  always_comb begin
    jump     = {meas_i[PixW-1], meas_i} - {prev_i[PixW-1], prev_i};
    jump_mag = jump[PixW] ? (~jump + 1'b1) : jump;
    glitch   = jump_mag > {2'b00, cfg_i.jump_limit, 1'b0};
  end

  // Error toward setpoint zero, saturated so that it fits the offset width.
  always_comb begin
    if (meas_i == {1'b1, {(PixW-1){1'b0}}}) begin
      err = {1'b0, {(PixW-1){1'b1}}};
    end else begin
      err = -meas_i;
    end
    err_sum   = {err[PixW-1], err} + {last_err_q[PixW-1], last_err_q};
    meas_diff = {meas_i[PixW-1], meas_i} - {last_meas_q[PixW-1], last_meas_q};
  end

  // The three gain products, each unsigned gain against a signed pixel value.
  always_comb begin
    prop_prod  = $signed({1'b0, cfg_i.prop_gain}) * err;
    integ_prod = $signed({1'b0, cfg_i.integ_gain}) * err_sum;
    deriv_prod = $signed({1'b0, cfg_i.deriv_gain}) * meas_diff;
  end

  // Saturating accumulators for the trapezoidal integral and the derivative.
  always_comb begin
    integ_sum = {integ_q[AccW-1], integ_q} + {{6{integ_prod[42]}}, integ_prod};
    deriv_sum = {deriv_q[AccW-1], deriv_q} + {{6{deriv_prod[42]}}, deriv_prod};
    integ_d   = spid_pkg::sat_acc(integ_sum);
    deriv_d   = spid_pkg::sat_acc(deriv_sum);
  end

  // Sum of the terms, rounded to Q8.8 with ties up, then clamped to the limit.
  always_comb begin
    total   = {{8{prop_prod[41]}}, prop_prod}
            + {{2{integ_d[AccW-1]}}, integ_d}
            + {{2{deriv_d[AccW-1]}}, deriv_d};
    rounded = total + {{(TotW-20){1'b0}}, 1'b1, 19'd0};
    ang_q88 = rounded[TotW-1:20];
    lim     = {{(RndW-spid_pkg::LimW){1'b0}}, cfg_i.angle_limit};
    if (ang_q88 > lim) begin
      ang_new = lim[AngW-1:0];
    end else if (ang_q88 < -lim) begin
      ang_new = -lim[AngW-1:0];
    end else begin
      ang_new = ang_q88[AngW-1:0];
    end
  end

  assign glitch_o = glitch;
  assign angle_o  = glitch ? held_q : ang_new;

  // Controller state moves only when a beat is committed and is not a glitch.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q     <= '0;
      deriv_q     <= '0;
      last_err_q  <= '0;
      last_meas_q <= '0;
      held_q      <= '0;
    end else if (commit_i && !glitch) begin
      integ_q     <= integ_d;
      deriv_q     <= deriv_d;
      last_err_q  <= err;
      last_meas_q <= meas_i;
      held_q      <= ang_new;
    end
  end

endmodule

// ----- design/steering_pid_controller.sv -----
// Steering PID controller: one offset beat in, one steering angle beat out.
// Path: an accepted input beat passes the input register, then the result register.
// Throughput: one beat per cycle while the output is not stalled; the input register
// feeds the PID datapath, whose result and controller state are both written in the same cycle.
// Reset: asynchronous, active low; clears the pipeline, the accumulators and the
// held angle, and loads the configuration registers with their default values.
module steering_pid_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [spid_pkg::PixW-1:0]    offset_i,
  input  logic signed [spid_pkg::PixW-1:0]    previous_offset_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [spid_pkg::AngW-1:0]    steering_angle_o,
  output logic                                glitch_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [spid_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [spid_pkg::GainW-1:0]          cfg_data_i
);

  spid_pkg::cfg_t cfg;

  logic                               s1_valid_q;
  logic signed [spid_pkg::PixW-1:0]   s1_offset_q;
  logic signed [spid_pkg::PixW-1:0]   s1_prev_q;
  logic                               out_valid_q;
  logic signed [spid_pkg::AngW-1:0]   out_angle_q;
  logic                               out_glitch_q;
  logic                               adv;
  logic                               in_fire;
  logic                               commit;
  logic signed [spid_pkg::AngW-1:0]   core_angle;
  logic                               core_glitch;

  // Configuration registers.
  spid_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Flow control: the result register frees up when empty or when its beat leaves.
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !adv;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign commit     = s1_valid_q && adv;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_offset_q <= offset_i;
      s1_prev_q   <= previous_offset_i;
    end
  end

  // PID datapath and controller state.
  spid_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .commit_i (commit),
    .meas_i   (s1_offset_q),
    .prev_i   (s1_prev_q),
    .angle_o  (core_angle),
    .glitch_o (core_glitch)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_angle_q  <= core_angle;
      out_glitch_q <= core_glitch;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign steering_angle_o = out_angle_q;
  assign glitch_o         = out_glitch_q;

  // A committed beat always shows up in the result register on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("committed beat did not reach the result register");

  // An empty input register never pushes back on the input channel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled while the input register is empty");

  // With nothing in flight, a delivered result leaves the output empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !s1_valid_q) |=> !out_valid_q)
    else $error("result repeated after delivery");

endmodule

// ----- sim/steering_pid_checker.sv -----
// Checker for the steering PID controller: predicts every steering beat and compares it.
`timescale 1ns / 1ps
module steering_pid_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic signed [spid_pkg::PixW-1:0]     offset_i,
  input  logic signed [spid_pkg::PixW-1:0]     previous_offset_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic signed [spid_pkg::AngW-1:0]     steering_angle_i,
  input  logic                                 glitch_i,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_i,
  input  logic [spid_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [spid_pkg::GainW-1:0]           cfg_data_i,
  input  logic                                 wrap_up_i,
  output int unsigned                          pending_o,
  output int unsigned                          fail_count_o,
  output int unsigned                          checked_o,
  output int unsigned                          glitches_o
);

  // One steering beat as the controller should emit it.
  typedef struct packed {
    logic signed [spid_pkg::AngW-1:0] steering_angle;
    logic                             glitch;
  } steer_beat_t;

  localparam longint AccMax   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint AccMin   = -AccMax - 1;
  localparam longint HalfLsb  = 64'sd524288;
  localparam int     DropBits = 20;

  // Shadow copy of the configuration registers.
  logic [spid_pkg::GainW-1:0] kp;
  logic [spid_pkg::GainW-1:0] ki;
  logic [spid_pkg::GainW-1:0] kd;
  logic [spid_pkg::LimW-1:0]  ang_lim;
  logic [spid_pkg::JumpW-1:0] jmp_lim;

  // Shadow copy of the controller state.
  longint                           integ_acc;
  longint                           deriv_acc;
  int                               prev_err;
  int                               prev_meas;
  logic signed [spid_pkg::AngW-1:0] hold_ang;

  steer_beat_t steer_expect_q[$];
  int unsigned fails;
  int unsigned checked;
  int unsigned glitches;
  logic        wrapped;

  function automatic longint clamp_acc(input longint v);
    longint r;
    r = v;
    if (v > AccMax) r = AccMax;
    if (v < AccMin) r = AccMin;
    return r;
  endfunction

  // Work out the steering beat for one offset beat and advance the shadow state.
  task automatic predict_steer(input logic signed [spid_pkg::PixW-1:0] meas_in,
                               input logic signed [spid_pkg::PixW-1:0] prev_in,
                               output steer_beat_t beat);
    int     meas;
    int     prev;
    int     jump;
    int     err;
    longint prop;
    longint total;
    longint ang;
    longint lim;
    meas = int'(meas_in);
    prev = int'(prev_in);
    jump = meas - prev;
    if (jump < 0) jump = -jump;
    if (jump > 2 * int'(jmp_lim)) begin
      // Implausible jump: repeat the held angle and leave the state alone.
      beat.steering_angle = hold_ang;
      beat.glitch = 1'b1;
    end else begin
      err = -meas;
      if (err > 255) err = 255;
      prop = longint'({32'd0, kp}) * longint'(err);
      integ_acc = clamp_acc(integ_acc + longint'({32'd0, ki}) * longint'(err + prev_err));
      deriv_acc = clamp_acc(deriv_acc + longint'({32'd0, kd}) * longint'(meas - prev_meas));
      total = prop + integ_acc + deriv_acc;
      // Round to Q8.8, halves going up, then clamp to the angle limit.
      ang = (total + HalfLsb) >>> DropBits;
      lim = longint'({50'd0, ang_lim});
      if (ang > lim) ang = lim;
      if (ang < -lim) ang = -lim;
      prev_err = err;
      prev_meas = meas;
      hold_ang = ang[spid_pkg::AngW-1:0];
      beat.steering_angle = hold_ang;
      beat.glitch = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    steer_beat_t want;
    if (!rst_ni) begin
      kp = spid_pkg::PropGainRst;
      ki = spid_pkg::IntegGainRst;
      kd = spid_pkg::DerivGainRst;
      ang_lim = spid_pkg::AngleLimRst;
      jmp_lim = spid_pkg::JumpLimRst;
      integ_acc = 0;
      deriv_acc = 0;
      prev_err = 0;
      prev_meas = 0;
      hold_ang = '0;
      steer_expect_q.delete();
      fails = 0;
      checked = 0;
      glitches = 0;
      wrapped = 1'b0;
    end else begin
      // Result side: compare against the oldest expectation.
      if (out_valid_i && !out_stall_i) begin
        if (steer_expect_q.size() == 0) begin
          $error("unexpected steering beat: steering_angle %0d, glitch %0b",
                 steering_angle_i, glitch_i);
          fails++;
        end else begin
          want = steer_expect_q.pop_front();
          checked++;
          if (want.glitch) glitches++;
          if (steering_angle_i !== want.steering_angle) begin
            $error("steering_angle mismatch: expected %0d, actual %0d",
                   want.steering_angle, steering_angle_i);
            fails++;
          end
          if (glitch_i !== want.glitch) begin
            $error("glitch mismatch: expected %0b, actual %0b", want.glitch, glitch_i);
            fails++;
          end
        end
      end

      // Input side: each accepted offset beat yields exactly one steering beat.
      if (in_valid_i && !in_stall_i) begin
        predict_steer(offset_i, previous_offset_i, want);
        steer_expect_q.push_back(want);
      end

      // Register writes; indexes past the list are dropped.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          spid_pkg::CFG_PROP_GAIN:   kp = cfg_data_i;
          spid_pkg::CFG_INTEG_GAIN:  ki = cfg_data_i;
          spid_pkg::CFG_DERIV_GAIN:  kd = cfg_data_i;
          spid_pkg::CFG_ANGLE_LIMIT: ang_lim = cfg_data_i[spid_pkg::LimW-1:0];
          spid_pkg::CFG_JUMP_LIMIT:  jmp_lim = cfg_data_i[spid_pkg::JumpW-1:0];
          default: ;
        endcase
      end

      // At the end of the run anything still queued never showed up.
      if (wrap_up_i && !wrapped) begin
        wrapped = 1'b1;
        if (steer_expect_q.size() != 0) begin
          $error("%0d expected steering beats never arrived", steer_expect_q.size());
          fails += steer_expect_q.size();
        end
      end
    end
    pending_o <= steer_expect_q.size();
    fail_count_o <= fails;
    checked_o <= checked;
    glitches_o <= glitches;
  end

endmodule

// ----- sim/tb_steering_pid_controller.sv -----
// Testbench top for the steering PID controller: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module tb_steering_pid_controller;

  typedef logic [spid_pkg::CfgIdxW-1:0] cfg_index_t;

  localparam int                                IdleLimit     = 1000;
  localparam logic [spid_pkg::GainW-1:0]        GainMax       = '1;
  localparam logic [spid_pkg::GainW-1:0]        AngleLimTop   = 32'd11520;
  localparam logic [spid_pkg::GainW-1:0]        JumpLimTop    = 32'd127;
  localparam logic signed [spid_pkg::PixW-1:0]  PixMin        = 9'sh100;
  localparam logic signed [spid_pkg::PixW-1:0]  PixMax        = 9'sh0FF;
  localparam cfg_index_t CfgIdxSpareLo = cfg_index_t'(spid_pkg::CFG_JUMP_LIMIT + 1);
  localparam cfg_index_t CfgIdxSpareHi = '1;

  typedef enum {MIX_FULL, MIX_NEG_OFFSET, MIX_POS_OFFSET, MIX_NEAR_CENTER} offset_mix_e;
  typedef enum {STALL_NONE, STALL_HOLD, STALL_CHOPPY} stall_mode_e;

  logic                                clk_i;
  logic                                rst_ni = 1'b0;
  logic                                in_valid_i = 1'b0;
  logic                                in_stall_o;
  logic signed [spid_pkg::PixW-1:0]    offset_i = '0;
  logic signed [spid_pkg::PixW-1:0]    previous_offset_i = '0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic signed [spid_pkg::AngW-1:0]    steering_angle_o;
  logic                                glitch_o;
  logic                                cfg_valid_i = 1'b0;
  logic                                cfg_ready_o;
  logic [spid_pkg::CfgIdxW-1:0]        cfg_index_i = spid_pkg::CFG_PROP_GAIN;
  logic [spid_pkg::GainW-1:0]          cfg_data_i = '0;
  logic                                wrap_up = 1'b0;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned checked;
  int unsigned glitches;

  int          beats_sent = 0;
  int          reg_writes = 0;
  int          settings_used = 1;
  int          burst_left = 0;
  int          jump_lim = int'(spid_pkg::JumpLimRst);
  int          idle_cycles = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_left = 0;

  steering_pid_controller dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .offset_i          (offset_i),
    .previous_offset_i (previous_offset_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .steering_angle_o  (steering_angle_o),
    .glitch_o          (glitch_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  steering_pid_checker u_steer_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .offset_i          (offset_i),
    .previous_offset_i (previous_offset_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .steering_angle_i  (steering_angle_o),
    .glitch_i          (glitch_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .wrap_up_i         (wrap_up),
    .pending_o         (pending),
    .fail_count_o      (fail_count),
    .checked_o         (checked),
    .glitches_o        (glitches)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The receiver alternates between clear runs, long holds and choppy stalls.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          stall_mode = STALL_NONE;
          stall_left = $urandom_range(20, 60);
        end
        2: begin
          stall_mode = STALL_HOLD;
          stall_left = $urandom_range(1, 24);
        end
        default: begin
          stall_mode = STALL_CHOPPY;
          stall_left = $urandom_range(4, 30);
        end
      endcase
    end else begin
      stall_left = stall_left - 1;
    end
    case (stall_mode)
      STALL_HOLD:   out_stall_i <= 1'b1;
      STALL_CHOPPY: out_stall_i <= ($urandom_range(0, 9) < 3);
      default:      out_stall_i <= 1'b0;
    endcase
  end

  // Watchdog: give up when no beat moves on any channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $error("no beat accepted for %0d cycles, %0d steering beats outstanding",
             idle_cycles, pending);
      $display("steering_pid_controller verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Hold back new offsets until every steering beat has come back.
  task automatic settle_outputs();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // One register write; leaves the valid high so back-to-back writes stay clean.
  task automatic write_reg(input logic [spid_pkg::CfgIdxW-1:0] idx,
                           input logic [spid_pkg::GainW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    reg_writes++;
    if (idx == spid_pkg::CFG_JUMP_LIMIT) jump_lim = int'(data[spid_pkg::JumpW-1:0]);
  endtask

  task automatic apply_setting(input logic [spid_pkg::GainW-1:0] kp,
                               input logic [spid_pkg::GainW-1:0] ki,
                               input logic [spid_pkg::GainW-1:0] kd,
                               input logic [spid_pkg::GainW-1:0] alim,
                               input logic [spid_pkg::GainW-1:0] jlim);
    settle_outputs();
    write_reg(spid_pkg::CFG_PROP_GAIN, kp);
    write_reg(spid_pkg::CFG_INTEG_GAIN, ki);
    write_reg(spid_pkg::CFG_DERIV_GAIN, kd);
    write_reg(spid_pkg::CFG_ANGLE_LIMIT, alim);
    write_reg(spid_pkg::CFG_JUMP_LIMIT, jlim);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // Send one offset beat; bursts of random length with random gaps between them.
  task automatic send_offset(input logic signed [spid_pkg::PixW-1:0] meas,
                             input logic signed [spid_pkg::PixW-1:0] prev);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 7))
        0, 1, 2: gap = 0;
        7:       gap = $urandom_range(10, 20);
        default: gap = $urandom_range(1, 4);
      endcase
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid_i <= 1'b1;
    offset_i <= meas;
    previous_offset_i <= prev;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    beats_sent++;
  endtask

  // Move the derivative accumulator by one offset step under a given gain.
  task automatic kick_deriv(input logic [spid_pkg::GainW-1:0] gain,
                            input logic signed [spid_pkg::PixW-1:0] meas);
    settle_outputs();
    write_reg(spid_pkg::CFG_DERIV_GAIN, gain);
    cfg_valid_i <= 1'b0;
    send_offset(meas, meas);
  endtask

  function automatic logic signed [spid_pkg::PixW-1:0] clip_pix(input int v);
    int r;
    r = v;
    if (r > 255) r = 255;
    if (r < -256) r = -256;
    return r[spid_pkg::PixW-1:0];
  endfunction

  // Random offsets; the previous offset mostly lands near the jump bound.
  task automatic random_offsets(input int count, input offset_mix_e mix);
    int meas;
    int prev;
    int span;
    repeat (count) begin
      case (mix)
        MIX_NEG_OFFSET:  meas = int'($urandom_range(0, 76)) - 256;
        MIX_POS_OFFSET:  meas = int'($urandom_range(180, 255));
        MIX_NEAR_CENTER: meas = int'($urandom_range(0, 60)) - 30;
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 4))
              0:       meas = -256;
              1:       meas = 255;
              2:       meas = 0;
              3:       meas = -1;
              default: meas = 128;
            endcase
          end else begin
            meas = int'($urandom_range(0, 511)) - 256;
          end
        end
      endcase
      span = 2 * jump_lim + 2;
      if ($urandom_range(0, 99) < 85) begin
        prev = meas + int'($urandom_range(0, 2 * span)) - span;
      end else begin
        prev = int'($urandom_range(0, 511)) - 256;
      end
      send_offset(clip_pix(meas), clip_pix(prev));
      if ($urandom_range(0, 149) == 0) settle_outputs();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, saturated error, glitch bound on both sides.
    send_offset(0, 0);
    send_offset(255, 255);
    send_offset(-256, -256);
    send_offset(-256, 255);
    send_offset(255, -256);
    send_offset(127, 127);
    send_offset(-128, -128);
    send_offset(128, 128);
    send_offset(-1, -1);
    send_offset(1, 1);
    send_offset(40, 0);
    send_offset(0, 40);
    send_offset(41, 0);
    send_offset(-41, 0);
    send_offset(0, -40);
    send_offset(100, 60);
    send_offset(100, 59);
    send_offset(-256, -216);
    send_offset(-200, -200);
    send_offset(0, 0);
    random_offsets(100, MIX_FULL);

    // Largest proportional gain, widest limits.
    apply_setting(GainMax, '0, '0, AngleLimTop, JumpLimTop);
    random_offsets(100, MIX_FULL);

    // Everything zero: the angle is pinned and any jump is a glitch.
    apply_setting('0, '0, '0, '0, '0);
    random_offsets(60, MIX_FULL);

    // Largest integral gain, pushed into saturation one way and then the other.
    apply_setting(32'h0100_0000, GainMax, '0, AngleLimTop, JumpLimTop);
    random_offsets(100, MIX_NEG_OFFSET);
    random_offsets(180, MIX_POS_OFFSET);

    // Fully random registers.
    apply_setting($urandom(), $urandom(), $urandom(), $urandom_range(0, 11520),
                  $urandom_range(0, 127));
    random_offsets(120, MIX_FULL);

    // Small gains keep the sum inside the limit, so rounding shows.
    apply_setting($urandom_range(0, 2**24), $urandom_range(0, 2**22),
                  $urandom_range(0, 2**24), AngleLimTop, $urandom_range(0, 127));
    random_offsets(60, MIX_NEAR_CENTER);
    random_offsets(60, MIX_FULL);

    // Writes to unused indexes, and register data wider than the register.
    settle_outputs();
    repeat (3) begin
      write_reg(cfg_index_t'($urandom_range(CfgIdxSpareLo, CfgIdxSpareHi)), $urandom());
    end
    write_reg(spid_pkg::CFG_ANGLE_LIMIT, GainMax);
    write_reg(spid_pkg::CFG_JUMP_LIMIT, $urandom());
    cfg_valid_i <= 1'b0;
    settings_used++;
    random_offsets(80, MIX_FULL);

    // Ratchet the derivative accumulator into saturation by switching its gain
    // between steps, then walk back down far enough to expose the clipped value.
    apply_setting('0, '0, GainMax, AngleLimTop, JumpLimTop);
    repeat (80) begin
      kick_deriv(GainMax, PixMax);
      kick_deriv('0, PixMin);
    end
    repeat (66) begin
      kick_deriv(GainMax, PixMin);
      kick_deriv('0, PixMax);
    end

    // Back to the power-on values.
    apply_setting(spid_pkg::PropGainRst, spid_pkg::IntegGainRst, spid_pkg::DerivGainRst,
                  32'(spid_pkg::AngleLimRst), 32'(spid_pkg::JumpLimRst));
    random_offsets(100, MIX_FULL);

    // Drain, allow the pipeline tail, then collect the verdict.
    settle_outputs();
    repeat (4) @(posedge clk_i);
    wrap_up <= 1'b1;
    repeat (2) @(posedge clk_i);
    $display("Drove %0d offset beats through %0d register settings with %0d register writes.",
             beats_sent, settings_used, reg_writes);
    $display("Compared %0d steering beats, %0d of them glitch holds.", checked, glitches);
    if (fail_count == 0) begin
      $display("steering_pid_controller verification clean");
    end else begin
      $display("steering_pid_controller verification failed");
    end
    $finish;
  end

endmodule
